@@ sv/pip_pkg.sv @@
// package for the point-in-polygon test unit
// holds default sizes, input kind codes, the command opcode type and the
// command control struct shared by the front and back modules
package pip_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 64;
  localparam int unsigned COORD_BITS_DEF   = 16;

  // kind field codes on the input channel
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  // decoded command carried through the queue
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // head-of-queue control handed from front to back
  typedef struct packed {
    logic valid;
    op_e  op;
  } cmd_ctrl_t;

endpackage

@@ sv/point_in_polygon_test_unit.sv @@
// top level of the point-in-polygon test unit
// instantiates pip_front and pip_back; depends on pip_pkg
//
// Input channel (in_valid_i / in_stall_o) carries kind_i, coord_x_i and
// coord_y_i: kind 0 appends a vertex, 1 clears the polygon, 2 queries a point.
// Output channel (out_valid_o / out_stall_i) returns exactly one transaction
// per input transaction, in order, with status_o (1 when an append found the
// vertex store full) and inside_res_o (query result, 0 for other kinds).
// A two-entry command queue sits between the front end and the back end.
// Append, clear and unused kinds are accepted into the queue, popped by the
// back end and written to the output register. A query inside the bounding
// box walks the vertex memory one edge per cycle through its single read
// port; queries that miss the box or hit an empty store load their result
// without a walk, like the other kinds. Only one query is in flight.
// Reset empties the vertex store and the queue and drops any pending result.
// While the receiver stalls, the result stays in the output register, the
// back end holds, and the queue fills; in_stall_o rises once it is full.
module point_in_polygon_test_unit #(
  parameter int unsigned MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COORD_BITS   = pip_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   kind_i,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         status_o,
  output logic                         inside_res_o
);

  pip_pkg::cmd_ctrl_t          cmd_ctrl;
  logic signed [COORD_BITS-1:0] cmd_x, cmd_y;
  logic                        cmd_pop;

  // front end: decode and queue
  pip_front #(
    .CoordBits (COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .coord_x_i  (coord_x_i),
    .coord_y_i  (coord_y_i),
    .cmd_ctrl_o (cmd_ctrl),
    .cmd_x_o    (cmd_x),
    .cmd_y_o    (cmd_y),
    .cmd_pop_i  (cmd_pop)
  );

  // back end: vertex store and edge walker
  pip_back #(
    .MaxVertices (MAX_VERTICES),
    .CoordBits   (COORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_ctrl_i   (cmd_ctrl),
    .cmd_x_i      (cmd_x),
    .cmd_y_i      (cmd_y),
    .cmd_pop_o    (cmd_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .inside_res_o (inside_res_o)
  );

endmodule

@@ sv/pip_front.sv @@
// front end of the point-in-polygon test unit: accepts input transactions,
// decodes the kind field and holds commands in a two-entry queue
// depends on pip_pkg
module pip_front #(
  parameter int unsigned CoordBits = pip_pkg::COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  logic signed [CoordBits-1:0] coord_x_i,
  input  logic signed [CoordBits-1:0] coord_y_i,
  output pip_pkg::cmd_ctrl_t          cmd_ctrl_o,
  output logic signed [CoordBits-1:0] cmd_x_o,
  output logic signed [CoordBits-1:0] cmd_y_o,
  input  logic                        cmd_pop_i
);

  pip_pkg::op_e               op_q [2];
  logic signed [CoordBits-1:0] x_q [2];
  logic signed [CoordBits-1:0] y_q [2];
  logic [1:0]                 cnt_q, cnt_d;
  logic                       wr_ptr_q, rd_ptr_q;
  logic                       push;
  pip_pkg::op_e               dec_op;

  // kind decode
  always_comb begin
    unique case (kind_i)
      pip_pkg::KIND_APPEND: dec_op = pip_pkg::OP_APPEND;
      pip_pkg::KIND_CLEAR:  dec_op = pip_pkg::OP_CLEAR;
      pip_pkg::KIND_QUERY:  dec_op = pip_pkg::OP_QUERY;
      default:              dec_op = pip_pkg::OP_NONE;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // queue entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_ptr_q] <= dec_op;
      x_q[wr_ptr_q]  <= coord_x_i;
      y_q[wr_ptr_q]  <= coord_y_i;
    end
  end

  assign cmd_ctrl_o.valid = (cnt_q != 2'd0);
  assign cmd_ctrl_o.op    = op_q[rd_ptr_q];
  assign cmd_x_o          = x_q[rd_ptr_q];
  assign cmd_y_o          = y_q[rd_ptr_q];

`ifndef NO_ASSERTIONS
  // back never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> (cnt_q != 2'd0))
    else $error("pop from empty command queue");
`endif

endmodule

@@ sv/pip_back.sv @@
// back end of the point-in-polygon test unit: vertex memory, bounding box,
// edge walker with a three-stage ray-casting pipeline and the result register
// depends on pip_pkg
module pip_back #(
  parameter int unsigned MaxVertices = pip_pkg::MAX_VERTICES_DEF,
  parameter int unsigned CoordBits   = pip_pkg::COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pip_pkg::cmd_ctrl_t          cmd_ctrl_i,
  input  logic signed [CoordBits-1:0] cmd_x_i,
  input  logic signed [CoordBits-1:0] cmd_y_i,
  output logic                        cmd_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        status_o,
  output logic                        inside_res_o
);

  localparam int unsigned AW    = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int unsigned CNT_W = $clog2(MaxVertices + 1);
  localparam int unsigned DW    = CoordBits + 1;
  localparam int unsigned PW    = 2 * DW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [CNT_W-1:0]            iss_q;
  logic signed [CoordBits-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic signed [CoordBits-1:0] qx_q, qy_q;

  logic signed [CoordBits-1:0] vx_mem [MaxVertices];
  logic signed [CoordBits-1:0] vy_mem [MaxVertices];
  logic signed [CoordBits-1:0] rd_x_q, rd_y_q, prev_x_q, prev_y_q;
  logic                        rd_vld_q, rd_first_q, rd_last_q;
  logic                        rd_issue;
  logic [CNT_W-1:0]            rd_addr_full;
  logic [AW-1:0]               rd_addr;

  logic                        s1_vld_q, s1_en_q, s1_last_q;
  logic signed [DW-1:0]        s1_dx_q, s1_dpy_q, s1_dpx_q, s1_dy_q;
  logic                        s2_vld_q, s2_en_q, s2_last_q;
  logic signed [PW-1:0]        s2_l_q, s2_r_q;
  logic                        acc_q, hit;

  logic                        out_valid_q, out_status_q, out_inside_q;
  logic                        out_free, out_load, out_status_d, out_inside_d;
  logic                        full, is_append, we, start_walk, early_out;
  logic signed [CoordBits-1:0] lo_x, lo_y, hi_x, hi_y;
  logic                        edge_en;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_ctrl_i.valid && out_free;
  assign full      = (count_q == CNT_W'(MaxVertices));
  assign is_append = (cmd_ctrl_i.op == pip_pkg::OP_APPEND);
  assign we        = cmd_pop_o && is_append && !full;

  // query rejected before the walk: empty store or outside the box
  assign early_out = (count_q == '0) ||
                     (cmd_x_i < min_x_q) || (cmd_y_i < min_y_q) ||
                     (cmd_x_i > max_x_q) || (cmd_y_i > max_y_q);
  assign start_walk = cmd_pop_o && (cmd_ctrl_i.op == pip_pkg::OP_QUERY) && !early_out;

  // read sequence: last vertex first, then 0 .. n-1
  assign rd_issue     = (state_q == S_WALK);
  assign rd_addr_full = (iss_q == '0) ? count_q - CNT_W'(1) : iss_q - CNT_W'(1);
  assign rd_addr      = rd_addr_full[AW-1:0];

  // control sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    out_load     = 1'b0;
    out_status_d = 1'b0;
    out_inside_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_pop_o) begin
          unique case (cmd_ctrl_i.op)
            pip_pkg::OP_APPEND: begin
              out_load     = 1'b1;
              out_status_d = full;
              if (!full) begin
                count_d = count_q + CNT_W'(1);
              end
            end
            pip_pkg::OP_CLEAR: begin
              out_load = 1'b1;
              count_d  = '0;
            end
            pip_pkg::OP_QUERY: begin
              if (early_out) begin
                out_load = 1'b1;
              end else begin
                state_d = S_WALK;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_WALK: begin
        if (iss_q == count_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (s2_vld_q && s2_last_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_inside_d = acc_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      iss_q       <= '0;
      rd_vld_q    <= 1'b0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_vld_q <= rd_issue;
      s1_vld_q <= rd_vld_q;
      s2_vld_q <= s1_vld_q;
      if (start_walk) begin
        iss_q <= '0;
      end else if (rd_issue) begin
        iss_q <= iss_q + CNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // vertex memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      vx_mem[count_q[AW-1:0]] <= cmd_x_i;
      vy_mem[count_q[AW-1:0]] <= cmd_y_i;
    end
    if (rd_issue) begin
      rd_x_q <= vx_mem[rd_addr];
      rd_y_q <= vy_mem[rd_addr];
    end
  end

  // bounding box and query point
  always_ff @(posedge clk_i) begin
    if (we) begin
      if (count_q == '0) begin
        min_x_q <= cmd_x_i;
        max_x_q <= cmd_x_i;
        min_y_q <= cmd_y_i;
        max_y_q <= cmd_y_i;
      end else begin
        if (cmd_x_i < min_x_q) min_x_q <= cmd_x_i;
        if (cmd_x_i > max_x_q) max_x_q <= cmd_x_i;
        if (cmd_y_i < min_y_q) min_y_q <= cmd_y_i;
        if (cmd_y_i > max_y_q) max_y_q <= cmd_y_i;
      end
    end
    if (start_walk) begin
      qx_q <= cmd_x_i;
      qy_q <= cmd_y_i;
    end
    if (rd_issue) begin
      rd_first_q <= (iss_q == '0);
      rd_last_q  <= (iss_q == count_q);
    end
  end

  // stage 1: order the edge ends by y, filter, form differences
  always_comb begin
    if (rd_y_q < prev_y_q) begin
      lo_x = rd_x_q;
      lo_y = rd_y_q;
      hi_x = prev_x_q;
      hi_y = prev_y_q;
    end else begin
      lo_x = prev_x_q;
      lo_y = prev_y_q;
      hi_x = rd_x_q;
      hi_y = rd_y_q;
    end
    edge_en = rd_vld_q && !rd_first_q && (rd_y_q != prev_y_q) &&
              !((rd_x_q < qx_q) && (prev_x_q < qx_q)) &&
              !(hi_y < qy_q) && !(lo_y >= qy_q);
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prev_x_q  <= rd_x_q;
      prev_y_q  <= rd_y_q;
      s1_en_q   <= edge_en;
      s1_last_q <= rd_last_q;
      s1_dx_q   <= DW'(hi_x) - DW'(lo_x);
      s1_dpy_q  <= DW'(qy_q) - DW'(lo_y);
      s1_dpx_q  <= DW'(qx_q) - DW'(lo_x);
      s1_dy_q   <= DW'(hi_y) - DW'(lo_y);
    end
  end

  // stage 2: cross products at full width
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_en_q   <= s1_en_q;
      s2_last_q <= s1_last_q;
      s2_l_q    <= PW'(s1_dx_q) * PW'(s1_dpy_q);
      s2_r_q    <= PW'(s1_dpx_q) * PW'(s1_dy_q);
    end
  end

  // stage 3: compare and toggle the inside bit
  assign hit = s2_vld_q && s2_en_q && (s2_l_q >= s2_r_q);

  always_ff @(posedge clk_i) begin
    if (start_walk) begin
      acc_q <= 1'b0;
    end else if (hit) begin
      acc_q <= !acc_q;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_inside_q <= out_inside_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign inside_res_o = out_inside_q;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MaxVertices))
    else $error("vertex count beyond capacity");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !cmd_pop_o)
    else $error("command popped while a query is in progress");

  a_last_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && s2_last_q) |-> (state_q == S_DRAIN))
    else $error("last edge token outside the drain phase");

  a_iss_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (iss_q <= count_q))
    else $error("read index ran past the vertex count");

  a_no_load_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !out_load)
    else $error("result register overwritten while stalled");
`endif

endmodule

@@ tb/sv/tb_point_in_polygon_test_unit.sv @@
// self-checking testbench for point_in_polygon_test_unit
// needs pip_pkg and the unit's rtl; predicts each result with its own ray-casting
// copy of the polygon store and checks results in order as they come back
module tb_point_in_polygon_test_unit;

  localparam int MAX_V        = pip_pkg::MAX_VERTICES_DEF;
  localparam int COORD_W      = pip_pkg::COORD_BITS_DEF;
  localparam int C_MIN        = -(1 << (COORD_W - 1));
  localparam int C_MAX        = (1 << (COORD_W - 1)) - 1;
  localparam int RANDOM_ITEMS = 420;
  localparam int QUIET_TAIL   = 60;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 400000;

  // kind value the unit must ignore
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } poly_cmd_t;

  typedef struct packed {
    logic status;
    logic in_poly;
  } poly_result_t;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               in_valid   = 1'b0;
  logic [1:0]         in_kind    = pip_pkg::KIND_APPEND;
  logic [COORD_W-1:0] in_x       = '0;
  logic [COORD_W-1:0] in_y       = '0;
  logic               out_stall  = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic               status;
  logic               inside_res;

  poly_cmd_t    pending_cmds[$];
  poly_result_t due_results[$];
  poly_cmd_t    next_cmd;
  poly_result_t got_due;

  // predicted polygon store
  logic signed [COORD_W-1:0] poly_x[MAX_V];
  logic signed [COORD_W-1:0] poly_y[MAX_V];
  int                        vert_n = 0;
  logic signed [COORD_W-1:0] box_min_x, box_max_x, box_min_y, box_max_y;

  int  n_total    = 0;
  int  n_accepted = 0;
  int  n_errors   = 0;
  int  n_cycles   = 0;
  int  send_gap   = 0;
  int  stall_left = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;
  logic bursts_on;

  point_in_polygon_test_unit #(
    .MAX_VERTICES(MAX_V),
    .COORD_BITS  (COORD_W)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .kind_i      (in_kind),
    .coord_x_i   (in_x),
    .coord_y_i   (in_y),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .inside_res_o(inside_res)
  );

  always #4 clk_i = ~clk_i;

  // random idling in alternating stretches, none near the end
  assign bursts_on = (n_accepted + QUIET_TAIL < n_total) && ((n_accepted / 40) % 4 != 3);

  // ray-casting test of one point against the predicted polygon
  function automatic logic point_inside(input logic signed [COORD_W-1:0] px,
                                        input logic signed [COORD_W-1:0] py);
    longint qx, qy, ax, ay, bx, by, sw;
    int     j;
    logic   hit;
    hit = 1'b0;
    qx  = px;
    qy  = py;
    if (vert_n == 0) return 1'b0;
    if (px < box_min_x || py < box_min_y || px > box_max_x || py > box_max_y) return 1'b0;
    for (int i = 0; i < vert_n; i++) begin
      j  = (i != 0) ? i - 1 : vert_n - 1;
      ax = poly_x[i];
      ay = poly_y[i];
      bx = poly_x[j];
      by = poly_y[j];
      // horizontal edges and edges wholly left of the point never count
      if (ay != by && !(ax < qx && bx < qx)) begin
        if (ay > by) begin
          sw = ax; ax = bx; bx = sw;
          sw = ay; ay = by; by = sw;
        end
        if (ay < qy && qy <= by && (bx - ax) * (qy - ay) >= (qx - ax) * (by - ay))
          hit = !hit;
      end
    end
    return hit;
  endfunction

  // apply one accepted transaction to the predicted store, queue its result
  function automatic void predict_polygon_cmd(input logic [1:0]         kind,
                                              input logic [COORD_W-1:0] x_raw,
                                              input logic [COORD_W-1:0] y_raw);
    poly_result_t r;
    logic signed [COORD_W-1:0] x, y;
    r = '0;
    x = x_raw;
    y = y_raw;
    case (kind)
      pip_pkg::KIND_APPEND: begin
        if (vert_n >= MAX_V) begin
          r.status = 1'b1;
        end else begin
          if (vert_n == 0) begin
            box_min_x = x; box_max_x = x;
            box_min_y = y; box_max_y = y;
          end else begin
            if (x < box_min_x) box_min_x = x;
            if (x > box_max_x) box_max_x = x;
            if (y < box_min_y) box_min_y = y;
            if (y > box_max_y) box_max_y = y;
          end
          poly_x[vert_n] = x;
          poly_y[vert_n] = y;
          vert_n++;
        end
      end
      pip_pkg::KIND_CLEAR: vert_n = 0;
      pip_pkg::KIND_QUERY: r.in_poly = point_inside(x, y);
      default: ;
    endcase
    due_results.push_back(r);
  endfunction

  task automatic push_cmd(input logic [1:0] kind, input int x, input int y);
    poly_cmd_t c;
    c.kind = kind;
    c.x    = x[COORD_W-1:0];
    c.y    = y[COORD_W-1:0];
    pending_cmds.push_back(c);
  endtask

  function automatic int rand_coord();
    return C_MIN + int'($urandom_range(0, (1 << COORD_W) - 1));
  endfunction

  function automatic int near_coord(input int centre, input int span);
    int v;
    v = centre + int'($urandom_range(0, 2 * span)) - span;
    if (v < C_MIN) v = C_MIN;
    if (v > C_MAX) v = C_MAX;
    return v;
  endfunction

  // optional clear, a run of appends around one spot, then queries mostly aimed at its box
  task automatic add_polygon_set(input bit fill_up);
    int n, nq, span, cx, cy, x, y, lo_x, hi_x, lo_y, hi_y, pick;
    int vx[$];
    int vy[$];
    if (fill_up || $urandom_range(0, 4) != 0)
      push_cmd(pip_pkg::KIND_CLEAR, rand_coord(), rand_coord());
    if (fill_up || $urandom_range(0, 15) == 0) n = MAX_V + $urandom_range(1, 3);
    else n = $urandom_range(1, 12);
    case ($urandom_range(0, 4))
      0:       span = 3;
      1:       span = 60;
      2:       span = 2000;
      3:       span = 20000;
      default: span = 1 << COORD_W;
    endcase
    cx = rand_coord();
    cy = rand_coord();
    for (int k = 0; k < n; k++) begin
      x = near_coord(cx, span);
      y = near_coord(cy, span);
      if (k == 0) begin
        lo_x = x; hi_x = x; lo_y = y; hi_y = y;
      end else begin
        if (x < lo_x) lo_x = x;
        if (x > hi_x) hi_x = x;
        if (y < lo_y) lo_y = y;
        if (y > hi_y) hi_y = y;
      end
      vx.push_back(x);
      vy.push_back(y);
      push_cmd(pip_pkg::KIND_APPEND, x, y);
    end
    nq = $urandom_range(2, 8);
    for (int k = 0; k < nq; k++) begin
      pick = $urandom_range(0, vx.size() - 1);
      case ($urandom_range(0, 9))
        // on or aligned with a vertex
        6, 7: begin
          x = vx[pick];
          y = vy[$urandom_range(0, vy.size() - 1)];
        end
        // just past one side of the box
        8: begin
          x = ($urandom_range(0, 1) != 0) ? lo_x - 1 : hi_x + 1;
          y = lo_y + int'($urandom_range(0, hi_y - lo_y));
        end
        9: begin
          x = rand_coord();
          y = rand_coord();
        end
        default: begin
          x = lo_x + int'($urandom_range(0, hi_x - lo_x));
          y = lo_y + int'($urandom_range(0, hi_y - lo_y));
        end
      endcase
      push_cmd(pip_pkg::KIND_QUERY, x, y);
    end
  endtask

  // input driver: offers queued commands, predicts each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin : cmd_driver
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_polygon_cmd(in_kind, in_x, in_y);
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0 && bursts_on && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          next_cmd = pending_cmds.pop_front();
          in_valid <= 1'b1;
          in_kind  <= next_cmd.kind;
          in_x     <= next_cmd.x;
          in_y     <= next_cmd.y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off partway through so the unit backs up
  always @(posedge clk_i or negedge rst_ni) begin : backpressure
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor: checks each result transaction against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("unexpected result transaction: status %0b inside_res %0b", status, inside_res);
          n_errors++;
        end else begin
          got_due = due_results.pop_front();
          if (status !== got_due.status) begin
            $error("status mismatch: expected %0b, actual %0b", got_due.status, status);
            n_errors++;
          end
          if (inside_res !== got_due.in_poly) begin
            $error("inside_res mismatch: expected %0b, actual %0b", got_due.in_poly, inside_res);
            n_errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_stall <= 1'b1;
      end else if (bursts_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= (hold_left != 0);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    // directed: empty store, ignored kind, extreme square, horizontal edge
    push_cmd(pip_pkg::KIND_QUERY, 0, 0);
    push_cmd(pip_pkg::KIND_QUERY, C_MIN, C_MAX);
    push_cmd(KIND_UNUSED, C_MAX, C_MIN);
    push_cmd(pip_pkg::KIND_CLEAR, -1, -1);
    push_cmd(pip_pkg::KIND_APPEND, C_MIN, C_MIN);
    push_cmd(pip_pkg::KIND_APPEND, C_MAX, C_MIN);
    push_cmd(pip_pkg::KIND_APPEND, C_MAX, C_MAX);
    push_cmd(pip_pkg::KIND_APPEND, C_MIN, C_MAX);
    push_cmd(pip_pkg::KIND_QUERY, 0, 0);
    push_cmd(pip_pkg::KIND_QUERY, C_MIN, C_MIN);
    push_cmd(pip_pkg::KIND_QUERY, C_MAX, C_MAX);
    push_cmd(pip_pkg::KIND_QUERY, C_MAX, 0);
    push_cmd(pip_pkg::KIND_CLEAR, 0, 0);
    push_cmd(pip_pkg::KIND_QUERY, 0, 0);
    push_cmd(pip_pkg::KIND_APPEND, 0, 0);
    push_cmd(pip_pkg::KIND_APPEND, 100, 0);
    push_cmd(pip_pkg::KIND_APPEND, 50, 100);
    push_cmd(pip_pkg::KIND_QUERY, 50, 50);
    push_cmd(pip_pkg::KIND_QUERY, 50, 0);
    push_cmd(pip_pkg::KIND_QUERY, 200, 50);
    push_cmd(pip_pkg::KIND_QUERY, 50, -1);
    push_cmd(pip_pkg::KIND_APPEND, -5, 200);
    push_cmd(pip_pkg::KIND_QUERY, 0, 100);
    push_cmd(KIND_UNUSED, 0, 0);

    // random: first set overfills the store, then mostly sets with some noise
    n_total = pending_cmds.size() + RANDOM_ITEMS;
    add_polygon_set(1'b1);
    while (pending_cmds.size() < n_total) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4))
          push_cmd(2'($urandom_range(0, 3)), rand_coord(), rand_coord());
      end else begin
        add_polygon_set(1'b0);
      end
    end
    n_total = pending_cmds.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_total || due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ point_in_polygon_test_unit.f @@
sv/pip_pkg.sv
sv/pip_front.sv
sv/pip_back.sv
sv/point_in_polygon_test_unit.sv
tb/sv/tb_point_in_polygon_test_unit.sv
